// ===== rtl/core/lrzf_pkg.sv =====
package lrzf_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MAX_RUN_WIDTH = 6;
    localparam int COUNT_WIDTH = 7;
    localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = 7'd64;
    localparam logic [MAX_RUN_WIDTH-1:0] MAX_RUN_RESET = 6'd3;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic                           stream_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_value;
        logic                           out_last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SETUP_END,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/core/long_run_zero_filter_top.sv =====
// Flow: an item is accepted in ST_IDLE and decided in ST_DECIDE in the next; a run that
// closes loads its results into the output register from ST_EMIT, which waits while the
// output register is full, and the final run of a stream is set up in ST_SETUP_END first.
// A new item is accepted only in ST_IDLE, once the last item and all of its results are
// done; the results go out one after another, counted by the single emission counter.
// Reset: synchronous, active low on aresetn; no run is open and max_run returns to 3.
module long_run_zero_filter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lrzf_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lrzf_pkg::out_item_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [lrzf_pkg::MAX_RUN_WIDTH-1:0]   cfg_wdata
);

    // Configuration register holding the longest run that is passed through as is.
    logic [lrzf_pkg::MAX_RUN_WIDTH-1:0] max_run_reg;

    // State of the open run.
    logic signed [lrzf_pkg::SAMPLE_WIDTH-1:0] run_sample_reg, run_sample_next;
    logic [lrzf_pkg::COUNT_WIDTH-1:0]         run_count_reg, run_count_next;
    logic                                     run_open_reg, run_open_next;

    // The item being worked on.
    logic signed [lrzf_pkg::SAMPLE_WIDTH-1:0] in_sample_reg, in_sample_next;
    logic                                     in_end_reg, in_end_next;

    // Emission sequencer: value to repeat, how many results remain, and whether this
    // burst is the one that closes the stream.
    logic signed [lrzf_pkg::SAMPLE_WIDTH-1:0] emit_value_reg, emit_value_next;
    logic [lrzf_pkg::COUNT_WIDTH-1:0]         emit_left_reg, emit_left_next;
    logic                                     emit_final_reg, emit_final_next;

    // Output register, which lets the block go back to idle while a result waits.
    logic                m_valid_reg, m_valid_next;
    lrzf_pkg::out_item_t m_data_reg, m_data_next;

    lrzf_pkg::state_t state_reg, state_next;

    // Shared compare unit. Both emission setups look at the stored run, so one
    // count-versus-limit compare serves them; the equality compare decides merging.
    logic run_long;
    logic sample_eq;
    logic slot_free;
    logic in_accept;

    assign run_long  = run_count_reg > {1'b0, max_run_reg};
    assign sample_eq = in_sample_reg == run_sample_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = state_reg == lrzf_pkg::ST_IDLE;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lrzf_pkg::ST_IDLE;
            max_run_reg   <= lrzf_pkg::MAX_RUN_RESET;
            run_sample_reg <= '0;
            run_count_reg <= '0;
            run_open_reg  <= 1'b0;
            emit_left_reg <= '0;
            emit_final_reg <= 1'b0;
            in_end_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                max_run_reg <= cfg_wdata;
            end
            run_sample_reg <= run_sample_next;
            run_count_reg <= run_count_next;
            run_open_reg  <= run_open_next;
            emit_left_reg <= emit_left_next;
            emit_final_reg <= emit_final_next;
            in_end_reg    <= in_end_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        in_sample_reg  <= in_sample_next;
        emit_value_reg <= emit_value_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        run_sample_next = run_sample_reg;
        run_count_next  = run_count_reg;
        run_open_next   = run_open_reg;
        in_sample_next  = in_sample_reg;
        in_end_next     = in_end_reg;
        emit_value_next = emit_value_reg;
        emit_left_next  = emit_left_reg;
        emit_final_next = emit_final_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            lrzf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    in_sample_next = s_data.sample_value;
                    in_end_next    = s_data.stream_end;
                    state_next     = lrzf_pkg::ST_DECIDE;
                end
            end
            lrzf_pkg::ST_DECIDE: begin
                if (run_open_reg && sample_eq) begin
                    // Same value: extend the run, saturating one above the largest limit.
                    if (run_count_reg < lrzf_pkg::COUNT_CAP) begin
                        run_count_next = run_count_reg + 1'b1;
                    end
                    state_next = in_end_reg ? lrzf_pkg::ST_SETUP_END : lrzf_pkg::ST_IDLE;
                end else begin
                    // A new run starts; an open run closes first without the last flag.
                    run_sample_next = in_sample_reg;
                    run_count_next  = {{(lrzf_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
                    run_open_next   = 1'b1;
                    if (run_open_reg) begin
                        emit_value_next = run_long ? '0 : run_sample_reg;
                        emit_left_next  = run_long ?
                            {{(lrzf_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1} : run_count_reg;
                        emit_final_next = 1'b0;
                        state_next      = lrzf_pkg::ST_EMIT;
                    end else begin
                        state_next = in_end_reg ? lrzf_pkg::ST_SETUP_END : lrzf_pkg::ST_IDLE;
                    end
                end
            end
            lrzf_pkg::ST_SETUP_END: begin
                // The stream ends: close the stored run with the last flag and clear it.
                emit_value_next = run_long ? '0 : run_sample_reg;
                emit_left_next  = run_long ?
                    {{(lrzf_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1} : run_count_reg;
                emit_final_next = 1'b1;
                run_sample_next = '0;
                run_count_next  = '0;
                run_open_next   = 1'b0;
                state_next      = lrzf_pkg::ST_EMIT;
            end
            lrzf_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_value = emit_value_reg;
                    m_data_next.out_last  = emit_final_reg &&
                        (emit_left_reg == {{(lrzf_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1});
                    emit_left_next        = emit_left_reg - 1'b1;
                    if (emit_left_reg == {{(lrzf_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1}) begin
                        if (!emit_final_reg && in_end_reg) begin
                            state_next = lrzf_pkg::ST_SETUP_END;
                        end else begin
                            state_next = lrzf_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = lrzf_pkg::ST_IDLE;
            end
        endcase
    end

    // An emission burst never starts or continues with nothing left to send.
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lrzf_pkg::ST_EMIT |-> emit_left_reg != '0)
        else $error("emission running with no results left");

    // The run counter saturates at its cap.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        run_count_reg <= lrzf_pkg::COUNT_CAP)
        else $error("run counter above its cap");

    // A run is open exactly when it has a nonzero length.
    a_open_count: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg == (run_count_reg != '0))
        else $error("run open flag and count disagree");

    // An accepted item is always decided in the following cycle.
    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == lrzf_pkg::ST_DECIDE)
        else $error("accepted item not decided");

    // While the burst that closes the stream is sent, the run state is already cleared.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lrzf_pkg::ST_EMIT && emit_final_reg |-> !run_open_reg)
        else $error("run still open while closing the stream");

endmodule
